>>> src/mset_pkg.sv
`default_nettype none
package mset_pkg;
    localparam int SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int IN_TIME_W = 32;
    localparam int REP_W = 17;
    localparam int FIRE_W = 16;
    localparam int EL_W = 16;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_CONFIG = 2'd1,
        ACT_PAUSE  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        EV_FIRED   = 2'd0,
        EV_REMOVED = 2'd1,
        EV_DONE    = 2'd2,
        EV_UNUSED  = 2'd3
    } t_event;
endpackage
`default_nettype wire

>>> src/mset_slot_mem.sv
`default_nettype none
module mset_slot_mem #(
    parameter int SLOTS     = mset_pkg::SLOTS_DEF,
    parameter int TIME_BITS = mset_pkg::TIME_BITS_DEF,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int DW = 4 * TIME_BITS + mset_pkg::REP_W + mset_pkg::FIRE_W + TIME_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> src/multi_slot_event_timer.sv
// Multi-slot event timer.
// One input channel (i_valid, o_stall) carries a transaction holding an action:
// configure a slot, set a slot's pause bit, or tick. One output channel
// (o_valid, i_stall) carries result transactions: fire, removal, tick done.
// Configure and pause are taken while idle and give no result; the next
// transaction can be accepted at the following edge.
// A tick walks the slots in index order. A slot that is invalid or paused is
// skipped in ST_READ; an active slot passes ST_READ (memory read) and ST_UPD
// (update and write-back), which the registered read of the slot memory sets.
// ST_UPD and ST_DONE wait while the receiver stalls; the tick done result is
// registered in ST_DONE and reaches the output as the block returns to idle.
// Fires are reported as they happen; the walk ends after the first removal,
// and a tick done result with last set closes every tick.
// One item is worked on at a time; o_stall is high while a tick is in progress.
// Results are held in an output register; while the receiver stalls the walk
// waits and no result is lost.
// Reset clears valid and pause bits, the state and the output valid flag; slot
// data is written by a configure before any use.
`default_nettype none
module multi_slot_event_timer #(
    parameter int SLOTS     = mset_pkg::SLOTS_DEF,
    parameter int TIME_BITS = mset_pkg::TIME_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [3:0]  i_slot,
    input  wire logic [15:0] i_elapsed,
    input  wire logic [31:0] i_interval,
    input  wire logic [31:0] i_first_delay,
    input  wire logic signed [16:0] i_repeat_times,
    input  wire logic [31:0] i_remove_after,
    input  wire logic        i_pause_bit,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_slot_out,
    output logic [1:0]       o_event_res,
    output logic [15:0]      o_fire_count,
    output logic             o_last
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW = TIME_BITS;
    localparam int RW = mset_pkg::REP_W;
    localparam int FW = mset_pkg::FIRE_W;
    localparam int EW = mset_pkg::EL_W;
    localparam int SW = ((TW > EW) ? TW : EW) + 1;
    localparam int DW = 4 * TW + RW + FW + TW;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [TW-1:0] TMAX = '1;
    localparam logic [FW-1:0] FMAX = '1;
    localparam logic signed [RW-1:0] REP_FOREVER = '1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic [TW-1:0]        period;
        logic [TW-1:0]        delay;
        logic signed [RW-1:0] rep;
        logic [FW-1:0]        fired;
        logic [TW-1:0]        since;
        logic [TW-1:0]        life;
        logic [TW-1:0]        age;
    } t_entry;

    t_state r_state, n_state;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [SLOTS-1:0] r_paused, n_paused;
    logic [CW-1:0] r_idx, n_idx;
    logic [EW-1:0] r_el, n_el;
    logic r_ovalid, n_ovalid;
    logic [3:0] r_oslot, n_oslot;
    logic [1:0] r_oev, n_oev;
    logic [FW-1:0] r_ocnt, n_ocnt;
    logic r_olast, n_olast;

    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry wentry, rentry;
    logic [DW-1:0] mem_rdata;

    mset_slot_mem #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(wentry),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );
    assign rentry = t_entry'(mem_rdata);

    function automatic logic [TW-1:0] sat_in(input logic [mset_pkg::IN_TIME_W-1:0] v);
        logic [TW-1:0] res;
        if (TW >= 32) begin
            res = TW'(v);
        end else if ((v >> TW) != 32'd0) begin
            res = TMAX;
        end else begin
            res = TW'(v);
        end
        return res;
    endfunction

    logic accept, out_free, cfg_ok;
    logic [AW-1:0] cur;
    logic [SW-1:0] since_sum, age_sum;
    logic [TW-1:0] since_n, age_n;
    logic removing, delay_fire, period_fire;
    logic rep_inf;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign cfg_ok   = (32'(i_slot) < 32'(SLOTS));
    assign cur      = r_idx[AW-1:0];
    assign o_stall  = (r_state != ST_IDLE);

    assign rep_inf   = (rentry.rep == REP_FOREVER);
    assign since_sum = SW'(rentry.since) + SW'(r_el);
    assign age_sum   = SW'(rentry.age) + SW'(r_el);
    assign since_n   = (since_sum > SW'(TMAX)) ? TMAX : since_sum[TW-1:0];
    assign age_n     = (rentry.life == '0) ? rentry.age :
                       ((age_sum > SW'(TMAX)) ? TMAX : age_sum[TW-1:0]);
    assign removing  = (!rep_inf && ($signed({1'b0, rentry.fired}) >= rentry.rep))
                    || ((rentry.life != '0) && (age_n >= rentry.life));
    assign delay_fire  = (rentry.delay != '0) && (since_n >= rentry.delay);
    assign period_fire = (rentry.delay == '0) && (since_n >= rentry.period);

    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid;
        n_paused = r_paused;
        n_idx    = r_idx;
        n_el     = r_el;
        n_ovalid = r_ovalid && i_stall;
        n_oslot  = r_oslot;
        n_oev    = r_oev;
        n_ocnt   = r_ocnt;
        n_olast  = r_olast;
        mem_we    = 1'b0;
        mem_waddr = cur;
        mem_raddr = cur;
        wentry    = rentry;
        unique case (r_state)
            ST_IDLE: begin
                mem_waddr = AW'(i_slot);
                wentry.period = sat_in(i_interval);
                wentry.delay  = sat_in(i_first_delay);
                wentry.rep    = (i_repeat_times < REP_FOREVER) ? REP_FOREVER : i_repeat_times;
                wentry.fired  = '0;
                wentry.since  = '0;
                wentry.life   = sat_in(i_remove_after);
                wentry.age    = '0;
                if (accept) begin
                    priority case (mset_pkg::t_action'(i_action))
                        mset_pkg::ACT_TICK: begin
                            n_el    = i_elapsed;
                            n_idx   = '0;
                            n_state = ST_READ;
                        end
                        mset_pkg::ACT_CONFIG: begin
                            if (cfg_ok) begin
                                mem_we = 1'b1;
                                n_valid[AW'(i_slot)] = 1'b1;
                            end
                        end
                        mset_pkg::ACT_PAUSE: begin
                            if (cfg_ok) begin
                                n_paused[AW'(i_slot)] = i_pause_bit;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (r_idx == CW'(SLOTS)) begin
                    n_state = ST_DONE;
                end else if (!r_valid[cur] || r_paused[cur]) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (out_free) begin
                    mem_we = 1'b1;
                    wentry.since = since_n;
                    wentry.age   = age_n;
                    n_oslot = 4'(cur);
                    n_ocnt  = rentry.fired;
                    n_olast = 1'b0;
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_READ;
                    if (removing) begin
                        mem_we   = 1'b0;
                        n_valid[cur] = 1'b0;
                        n_ovalid = 1'b1;
                        n_oev    = mset_pkg::EV_REMOVED;
                        n_state  = ST_DONE;
                    end else if (delay_fire || period_fire) begin
                        wentry.since = '0;
                        if (delay_fire) begin
                            wentry.delay = '0;
                        end
                        if ((delay_fire || !rep_inf) && rentry.fired != FMAX) begin
                            wentry.fired = rentry.fired + 1'b1;
                        end
                        n_ocnt   = wentry.fired;
                        n_ovalid = 1'b1;
                        n_oev    = mset_pkg::EV_FIRED;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oslot  = '0;
                    n_oev    = mset_pkg::EV_DONE;
                    n_ocnt   = '0;
                    n_olast  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_paused <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_paused <= n_paused;
            r_ovalid <= n_ovalid;
        end
        r_idx   <= n_idx;
        r_el    <= n_el;
        r_oslot <= n_oslot;
        r_oev   <= n_oev;
        r_ocnt  <= n_ocnt;
        r_olast <= n_olast;
    end

    assign o_valid      = r_ovalid;
    assign o_slot_out   = r_oslot;
    assign o_event_res  = r_oev;
    assign o_fire_count = r_ocnt;
    assign o_last       = r_olast;

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("input taken while busy");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_event_res == mset_pkg::EV_DONE))
        else $error("last without tick done");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(o_valid && i_stall) && $past(i_rst_n)) |-> (o_valid && $stable(o_fire_count)))
        else $error("stalled result changed");
endmodule
`default_nettype wire

>>> tb/tb_multi_slot_event_timer.sv
`timescale 1ns / 1ps
module tb_multi_slot_event_timer;

    localparam int NSLOT = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  in_action = mset_pkg::ACT_TICK;
    logic [3:0]  in_slot = '0;
    logic [15:0] in_elapsed = '0;
    logic [31:0] in_interval = '0;
    logic [31:0] in_first_delay = '0;
    logic signed [16:0] in_repeat = '0;
    logic [31:0] in_remove_after = '0;
    logic        in_pause = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  out_slot;
    logic [1:0]  out_event;
    logic [15:0] out_count;
    logic        out_last;

    typedef struct packed {
        logic [3:0]        slot;
        mset_pkg::t_event  ev;
        logic [15:0]       count;
        logic              last;
    } t_timer_event;

    t_timer_event event_queue[$];

    bit          t_valid[NSLOT];
    bit          t_paused[NSLOT];
    logic [31:0] t_period[NSLOT];
    logic [31:0] t_delay[NSLOT];
    int          t_limit[NSLOT];
    int          t_fired[NSLOT];
    logic [31:0] t_since[NSLOT];
    logic [31:0] t_life[NSLOT];
    logic [31:0] t_age[NSLOT];

    int  mismatches = 0;
    int  results_seen = 0;
    bit  calm = 1'b0;

    always #6 clk = ~clk;

    multi_slot_event_timer u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_action(in_action), .i_slot(in_slot), .i_elapsed(in_elapsed),
        .i_interval(in_interval), .i_first_delay(in_first_delay),
        .i_repeat_times(in_repeat), .i_remove_after(in_remove_after),
        .i_pause_bit(in_pause), .o_valid(out_valid), .i_stall(out_stall),
        .o_slot_out(out_slot), .o_event_res(out_event), .o_fire_count(out_count),
        .o_last(out_last)
    );

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + b;
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void push_event(int s, mset_pkg::t_event ev, int cnt, bit lst);
        t_timer_event e;
        e.slot = s[3:0];
        e.ev = ev;
        e.count = cnt[15:0];
        e.last = lst;
        event_queue.insert(event_queue.size(), e);
    endfunction

    function automatic void predict_timer(logic [1:0] act, logic [3:0] s, logic [15:0] el,
                                          logic [31:0] iv, logic [31:0] fd,
                                          logic signed [16:0] rp, logic [31:0] ra, logic pb);
        int rep;
        bit gone;
        if (act == mset_pkg::ACT_CONFIG) begin
            rep = rp;
            if (rep < -1) begin
                rep = -1;
            end
            t_period[s] = iv;
            t_delay[s] = fd;
            t_limit[s] = rep;
            t_life[s] = ra;
            t_fired[s] = 0;
            t_since[s] = '0;
            t_age[s] = '0;
            t_valid[s] = 1'b1;
        end else if (act == mset_pkg::ACT_PAUSE) begin
            t_paused[s] = pb;
        end else if (act == mset_pkg::ACT_TICK) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (!t_valid[i] || t_paused[i]) begin
                    continue;
                end
                t_since[i] = sat_add(t_since[i], el);
                if (t_life[i] != 0) begin
                    t_age[i] = sat_add(t_age[i], el);
                end
                gone = (t_limit[i] != -1 && t_fired[i] >= t_limit[i]) ||
                       (t_life[i] != 0 && t_age[i] >= t_life[i]);
                if (gone) begin
                    t_valid[i] = 1'b0;
                    push_event(i, mset_pkg::EV_REMOVED, t_fired[i], 1'b0);
                    break;
                end
                if (t_delay[i] != 0) begin
                    if (t_since[i] >= t_delay[i]) begin
                        t_delay[i] = '0;
                        t_since[i] = '0;
                        if (t_fired[i] < 65535) begin
                            t_fired[i]++;
                        end
                        push_event(i, mset_pkg::EV_FIRED, t_fired[i], 1'b0);
                    end
                    continue;
                end
                if (t_since[i] >= t_period[i]) begin
                    t_since[i] = '0;
                    if (t_limit[i] != -1 && t_fired[i] < 65535) begin
                        t_fired[i]++;
                    end
                    push_event(i, mset_pkg::EV_FIRED, t_fired[i], 1'b0);
                end
            end
            push_event(0, mset_pkg::EV_DONE, 0, 1'b1);
        end
    endfunction

    task automatic send_item(logic [1:0] act, logic [3:0] s, logic [15:0] el,
                             logic [31:0] iv, logic [31:0] fd, logic signed [16:0] rp,
                             logic [31:0] ra, logic pb);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_action <= act;
        in_slot <= s;
        in_elapsed <= el;
        in_interval <= iv;
        in_first_delay <= fd;
        in_repeat <= rp;
        in_remove_after <= ra;
        in_pause <= pb;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        predict_timer(act, s, el, iv, fd, rp, ra, pb);
    endtask

    task automatic configure_slot(logic [3:0] s, logic [31:0] iv, logic [31:0] fd,
                                  logic signed [16:0] rp, logic [31:0] ra);
        send_item(mset_pkg::ACT_CONFIG, s, 16'($urandom), iv, fd, rp, ra, 1'($urandom));
    endtask

    task automatic tick(logic [15:0] el);
        send_item(mset_pkg::ACT_TICK, 4'($urandom), el, $urandom, $urandom,
                  17'($urandom), $urandom, 1'($urandom));
    endtask

    always @(posedge clk) begin
        t_timer_event e;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (event_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result: slot %0d event %0d count %0d last %0b",
                             out_slot, out_event, out_count, out_last);
                end
            end else begin
                e = event_queue.pop_front();
                if (out_slot !== e.slot || out_event !== e.ev || out_count !== e.count ||
                    out_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"Mismatch: expected slot %0d event %0d count %0d last %0b,",
                                  " got slot %0d event %0d count %0d last %0b"},
                                 e.slot, e.ev, e.count, e.last,
                                 out_slot, out_event, out_count, out_last);
                    end
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge clk) begin
        if (calm) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 12);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic test_extremes();
        configure_slot(4'd0, 32'd0, 32'd0, 17'sd3, 32'd0);
        configure_slot(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -17'sd1, 32'hFFFF_FFFF);
        configure_slot(4'd3, 32'd5, 32'd10, 17'sh10000, 32'd0);
        configure_slot(4'd4, 32'd7, 32'd0, 17'sd65535, 32'd40);
        configure_slot(4'd5, 32'd2, 32'd0, 17'sd0, 32'd0);
        tick(16'd0);
        tick(16'hFFFF);
        tick(16'd10);
        send_item(mset_pkg::ACT_NONE, 4'd6, 16'd5, 32'd1, 32'd1, 17'sd1, 32'd1, 1'b1);
        tick(16'd20);
        tick(16'd20);
        tick(16'd1);
    endtask

    task automatic test_pause();
        send_item(mset_pkg::ACT_PAUSE, 4'd9, 16'd0, '0, '0, '0, '0, 1'b1);
        configure_slot(4'd9, 32'd1, 32'd0, 17'sd2, 32'd0);
        tick(16'd3);
        send_item(mset_pkg::ACT_PAUSE, 4'd9, 16'd0, '0, '0, '0, '0, 1'b0);
        tick(16'd3);
        tick(16'd3);
        tick(16'd3);
        tick(16'hFFFF);
    endtask

    task automatic test_fire_saturation();
        configure_slot(4'd2, 32'd0, 32'd0, 17'sd65535, 32'd0);
        for (int i = 0; i < 4; i++) begin
            tick(16'd1);
        end
    endtask

    task automatic test_random(int n);
        int r;
        logic [31:0] iv;
        logic [31:0] fd;
        logic [31:0] ra;
        logic signed [16:0] rp;
        for (int i = 0; i < n; i++) begin
            if (i > n * 4 / 5) begin
                calm = 1'b1;
            end
            r = $urandom_range(0, 9);
            if (r < 3) begin
                iv = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60);
                fd = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 80) : 32'd0;
                if ($urandom_range(0, 3) == 0) begin
                    rp = 17'($urandom);
                end else begin
                    rp = $signed(17'($urandom_range(0, 6))) - 17'sd1;
                end
                if ($urandom_range(0, 1) == 1) begin
                    ra = 32'd0;
                end else if ($urandom_range(0, 4) == 0) begin
                    ra = $urandom;
                end else begin
                    ra = $urandom_range(1, 300);
                end
                configure_slot(4'($urandom), iv, fd, rp, ra);
            end else if (r == 3) begin
                send_item(mset_pkg::ACT_PAUSE, 4'($urandom), 16'($urandom), $urandom,
                          $urandom, 17'($urandom), $urandom, $urandom_range(0, 3) == 0);
            end else if (r == 4 && $urandom_range(0, 3) == 0) begin
                send_item(mset_pkg::ACT_NONE, 4'($urandom), 16'($urandom), $urandom,
                          $urandom, 17'($urandom), $urandom, 1'($urandom));
            end else begin
                tick(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)));
            end
        end
    endtask

    initial begin
        int guard;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_pause();
        test_fire_saturation();
        test_random(125);
        in_valid <= 1'b0;
        guard = 0;
        while (event_queue.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
        if (mismatches == 0 && event_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule

>>> multi_slot_event_timer.f
src/mset_pkg.sv
src/mset_slot_mem.sv
src/multi_slot_event_timer.sv
tb/tb_multi_slot_event_timer.sv
